// ===== src/csort_pkg.sv =====
// csort_pkg: shared types and constants for the counting sort block
// no dependencies; imported by counting_sort_nonnegative_top
package csort_pkg;

  // element and histogram widths fixed by the beat format
  localparam int VAL_W = 11;
  localparam int BIN_W = 7;
  // wide enough to compare any element against the saturation limit
  localparam int EXT_W = 17;
  localparam int STATUS_W = 2;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [BIN_W-1:0] bin_cnt_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [EXT_W-1:0] ext_t;

  // run status codes
  localparam status_t STATUS_SORTED    = 2'd0;
  localparam status_t STATUS_REJECTED  = 2'd1;
  localparam status_t STATUS_TRUNCATED = 2'd2;

endpackage

// ===== src/counting_sort_nonnegative_top.sv =====
// Counting sort of a set of signed elements loaded one beat at a time.
// A negative or dropped element is taken in the load state alone; a kept non-negative
// one also passes the write-back state (read, then write back of its histogram bin).
// After the last beat the block emits the run: a sorted run walks the bins from zero to
// the largest value, reading then clearing each bin and emitting one beat per result;
// a rejected run first replays the stored elements in arrival order (read, then output)
// and then does the same bin clearing walk. After reset the histogram is cleared one
// bin a cycle, all MAX_VALUE+1 bins, with in_stall held high. in_stall is also high
// during emission. Depends on csort_pkg.
module counting_sort_nonnegative_top
  import csort_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_VALUE = 1023
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  value_t  in_item_value,
  input  logic    in_item_last,
  output logic    out_valid,
  input  logic    out_stall,
  output value_t  out_value,
  output logic    out_last,
  output status_t out_run_status
);

  localparam int HW = (MAX_VALUE < 1) ? 1 : $clog2(MAX_VALUE + 1);
  localparam int HDEPTH = MAX_VALUE + 1;
  localparam int NW = $clog2(MAX_ITEMS + 1);
  localparam int IW = (MAX_ITEMS < 2) ? 1 : $clog2(MAX_ITEMS);

  // controller states
  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_LOAD      = 3'd1;
  localparam logic [2:0] ST_LOAD_WR   = 3'd2;
  localparam logic [2:0] ST_ORIG_RD   = 3'd3;
  localparam logic [2:0] ST_ORIG_OUT  = 3'd4;
  localparam logic [2:0] ST_WALK_RD   = 3'd5;
  localparam logic [2:0] ST_WALK_CHK  = 3'd6;
  localparam logic [2:0] ST_WALK_EMIT = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [HW-1:0] walk_addr_r, walk_addr_nxt;
  logic [HW-1:0] largest_r, largest_nxt;
  logic [HW-1:0] hist_addr_r, hist_addr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [NW-1:0] k_r, k_nxt;
  logic          neg_r, neg_nxt;
  logic          ovf_r, ovf_nxt;
  logic          last_pend_r, last_pend_nxt;
  bin_cnt_t      bin_cnt_r, bin_cnt_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  value_t  out_value_r;
  logic    out_last_r;
  status_t out_status_r;
  logic    out_load;
  value_t  out_load_value;
  logic    out_load_last;
  logic    out_free;

  // histogram memory ports
  bin_cnt_t      hist_mem [HDEPTH];
  bin_cnt_t      hist_rd_q;
  logic          hist_rd_en;
  logic [HW-1:0] hist_rd_addr;
  logic          hist_wr_en;
  logic [HW-1:0] hist_wr_addr;
  bin_cnt_t      hist_wr_data;

  // arrival order store ports
  value_t        store_mem [MAX_ITEMS];
  value_t        store_rd_q;
  logic          store_rd_en;
  logic [IW-1:0] store_rd_addr;
  logic          store_wr_en;
  logic [IW-1:0] store_wr_addr;
  value_t        store_wr_data;

  // input element saturation
  ext_t          pos_ext;
  ext_t          sat_ext;
  logic [HW-1:0] sat_addr;
  logic          in_neg;
  ext_t          walk_ext;
  status_t       status;
  logic          go_emit;
  logic          advance;
  logic          is_last_beat;

  assign in_neg   = in_item_value[VAL_W-1];
  assign pos_ext  = EXT_W'(in_item_value[VAL_W-2:0]);
  assign sat_ext  = (pos_ext > EXT_W'(MAX_VALUE)) ? EXT_W'(MAX_VALUE) : pos_ext;
  assign sat_addr = sat_ext[HW-1:0];
  assign walk_ext = EXT_W'(walk_addr_r);

  assign status = neg_r ? STATUS_REJECTED : (ovf_r ? STATUS_TRUNCATED : STATUS_SORTED);
  assign out_free = !out_valid_r || !out_stall;
  assign is_last_beat = ((k_r + NW'(1)) == count_r);

  assign in_stall       = (state_r != ST_LOAD);
  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_last       = out_last_r;
  assign out_run_status = out_status_r;

  // controller
  always_comb begin
    state_nxt     = state_r;
    walk_addr_nxt = walk_addr_r;
    largest_nxt   = largest_r;
    hist_addr_nxt = hist_addr_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    neg_nxt       = neg_r;
    ovf_nxt       = ovf_r;
    last_pend_nxt = last_pend_r;
    bin_cnt_nxt   = bin_cnt_r;
    hist_rd_en    = 1'b0;
    hist_rd_addr  = walk_addr_r;
    hist_wr_en    = 1'b0;
    hist_wr_addr  = walk_addr_r;
    hist_wr_data  = '0;
    store_rd_en   = 1'b0;
    store_rd_addr = k_r[IW-1:0];
    store_wr_en   = 1'b0;
    store_wr_addr = count_r[IW-1:0];
    store_wr_data = in_item_value;
    out_load      = 1'b0;
    out_load_value = store_rd_q;
    out_load_last = is_last_beat;
    go_emit       = 1'b0;
    advance       = 1'b0;

    case (state_r)
      // sweep the histogram to zero after reset
      ST_CLEAR: begin
        hist_wr_en = 1'b1;
        if (walk_addr_r == HW'(MAX_VALUE)) begin
          walk_addr_nxt = '0;
          state_nxt     = ST_LOAD;
        end else begin
          walk_addr_nxt = walk_addr_r + HW'(1);
        end
      end
      // take one beat, start the bin read for kept non-negative elements
      ST_LOAD: begin
        if (in_valid) begin
          last_pend_nxt = in_item_last;
          if (count_r < NW'(MAX_ITEMS)) begin
            store_wr_en = 1'b1;
            count_nxt   = count_r + NW'(1);
            if (in_neg) begin
              neg_nxt = 1'b1;
            end else begin
              store_wr_data = value_t'(sat_ext[VAL_W-1:0]);
              hist_rd_en    = 1'b1;
              hist_rd_addr  = sat_addr;
              hist_addr_nxt = sat_addr;
              if (sat_addr > largest_r) begin
                largest_nxt = sat_addr;
              end
              state_nxt = ST_LOAD_WR;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item_last && (state_nxt == ST_LOAD)) begin
            go_emit = 1'b1;
          end
        end
      end
      // write back the incremented bin
      ST_LOAD_WR: begin
        hist_wr_en   = 1'b1;
        hist_wr_addr = hist_addr_r;
        hist_wr_data = hist_rd_q + bin_cnt_t'(1);
        if (last_pend_r) begin
          go_emit = 1'b1;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      // replay arrival order for a rejected run
      ST_ORIG_RD: begin
        store_rd_en = 1'b1;
        state_nxt   = ST_ORIG_OUT;
      end
      ST_ORIG_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          k_nxt    = k_r + NW'(1);
          if (is_last_beat) begin
            walk_addr_nxt = '0;
            state_nxt     = ST_WALK_RD;
          end else begin
            state_nxt = ST_ORIG_RD;
          end
        end
      end
      // histogram walk: read the bin
      ST_WALK_RD: begin
        hist_rd_en = 1'b1;
        state_nxt  = ST_WALK_CHK;
      end
      // clear the bin and decide whether it emits
      ST_WALK_CHK: begin
        hist_wr_en  = 1'b1;
        bin_cnt_nxt = hist_rd_q;
        if (!neg_r && (hist_rd_q != '0) && (k_r != count_r)) begin
          state_nxt = ST_WALK_EMIT;
        end else begin
          advance = 1'b1;
        end
      end
      // one beat per copy of the bin value
      ST_WALK_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_load_value = value_t'(walk_ext[VAL_W-1:0]);
          k_nxt          = k_r + NW'(1);
          bin_cnt_nxt    = bin_cnt_r - bin_cnt_t'(1);
          if ((bin_cnt_r == bin_cnt_t'(1)) || is_last_beat) begin
            advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // next bin or end of run
    if (advance) begin
      if (walk_addr_r == largest_r) begin
        count_nxt     = '0;
        k_nxt         = '0;
        largest_nxt   = '0;
        neg_nxt       = 1'b0;
        ovf_nxt       = 1'b0;
        last_pend_nxt = 1'b0;
        walk_addr_nxt = '0;
        state_nxt     = ST_LOAD;
      end else begin
        walk_addr_nxt = walk_addr_r + HW'(1);
        state_nxt     = ST_WALK_RD;
      end
    end

    // run complete on input, pick the emission order
    if (go_emit) begin
      k_nxt         = '0;
      walk_addr_nxt = '0;
      state_nxt     = neg_nxt ? ST_ORIG_RD : ST_WALK_RD;
    end
  end

  // output register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_addr_r <= '0;
      largest_r   <= '0;
      count_r     <= '0;
      k_r         <= '0;
      neg_r       <= 1'b0;
      ovf_r       <= 1'b0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_addr_r <= walk_addr_nxt;
      largest_r   <= largest_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      neg_r       <= neg_nxt;
      ovf_r       <= ovf_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hist_addr_r <= hist_addr_nxt;
    bin_cnt_r   <= bin_cnt_nxt;
    if (out_load) begin
      out_value_r  <= out_load_value;
      out_last_r   <= out_load_last;
      out_status_r <= status;
    end
  end

  // histogram memory
  always_ff @(posedge clk) begin
    if (hist_wr_en) begin
      hist_mem[hist_wr_addr] <= hist_wr_data;
    end
    if (hist_rd_en) begin
      hist_rd_q <= hist_mem[hist_rd_addr];
    end
  end

  // arrival order memory
  always_ff @(posedge clk) begin
    if (store_wr_en) begin
      store_mem[store_wr_addr] <= store_wr_data;
    end
    if (store_rd_en) begin
      store_rd_q <= store_mem[store_rd_addr];
    end
  end

  // the run never holds more elements than the store
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= NW'(MAX_ITEMS))
    else $error("element count beyond capacity");

  // emission never runs past the kept elements
  assert property (@(posedge clk) disable iff (!rst_n) k_r <= count_r)
    else $error("emitted more beats than kept elements");

  // the walk never goes past the largest stored value
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK_RD || state_r == ST_WALK_CHK || state_r == ST_WALK_EMIT)
    |-> walk_addr_r <= largest_r)
    else $error("histogram walk past largest value");

  // an empty run starts from clean flags
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && count_r == '0) |-> (!neg_r && !ovf_r && largest_r == '0))
    else $error("run state not cleared between runs");

endmodule
